@@ rtl/msm_pkg.sv @@
package msm_pkg;

   localparam int CHANNELS = 4;
   localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ADDR_BITS = 14;
   localparam int MEM_DEPTH = 1 << ADDR_BITS;
   localparam int POS_BITS = 15;
   localparam int SAMPLE_BITS = 8;
   localparam int VOL_BITS = 8;
   localparam int CHAN_FIELD_BITS = 8;
   localparam int PROD_BITS = 17;
   localparam int SUM_BITS = PROD_BITS + CH_IDX_BITS;
   localparam int UNIT_BITS = 16;

   localparam logic [CH_IDX_BITS-1:0] LAST_CH = CH_IDX_BITS'(CHANNELS - 1);
   localparam logic signed [SUM_BITS-1:0] MID_OFFSET = SUM_BITS'(128 * 255);
   localparam logic signed [SUM_BITS-1:0] LEVEL_SPAN = SUM_BITS'(256 * 255 - 1);

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_PLAY  = 2'd1,
      MODE_STOP  = 2'd2,
      MODE_WRITE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MULT,
      ST_SUM,
      ST_SCALE,
      ST_OUT
   } state_type;

endpackage

@@ rtl/msm_if.sv @@
interface msm_req_if;
   logic                               valid;
   logic                               ready;
   msm_pkg::mode_type                  mode;
   logic [msm_pkg::CHAN_FIELD_BITS-1:0] channel;
   logic [msm_pkg::ADDR_BITS-1:0]      clip_start;
   logic [msm_pkg::POS_BITS-1:0]       clip_length;
   logic [msm_pkg::VOL_BITS-1:0]       volume;
   logic                               loop_enable;
   logic [msm_pkg::ADDR_BITS-1:0]      write_address;
   logic [msm_pkg::SAMPLE_BITS-1:0]    write_data;

   modport source (
      output valid, mode, channel, clip_start, clip_length, volume, loop_enable,
             write_address, write_data,
      input  ready
   );

   modport sink (
      input  valid, mode, channel, clip_start, clip_length, volume, loop_enable,
             write_address, write_data,
      output ready
   );
endinterface

interface msm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [msm_pkg::SAMPLE_BITS-1:0] sample_out;

   modport source (
      output valid, sample_out,
      input  ready
   );

   modport sink (
      input  valid, sample_out,
      output ready
   );
endinterface

@@ rtl/msm_scale.sv @@
module msm_scale (
   input  logic                                  clock,
   input  logic signed [msm_pkg::SUM_BITS-1:0]   sum,
   output logic [msm_pkg::SAMPLE_BITS-1:0]       level
);

   logic signed [msm_pkg::SUM_BITS-1:0] offset_sum;
   logic [msm_pkg::UNIT_BITS-1:0]       unit;
   logic [24:0]                         recip_prod;
   logic [msm_pkg::UNIT_BITS-1:0]       unit_ff;
   logic [msm_pkg::SAMPLE_BITS-1:0]     quot_ff;
   logic                                low_ff;
   logic                                high_ff;
   logic [msm_pkg::UNIT_BITS-1:0]       quot_x255;
   logic [msm_pkg::UNIT_BITS-1:0]       remainder;

   // The offset sum is the level times 255 when in range, so the level is a
   // floor division by 255 done with a reciprocal multiply and one correction.
   assign offset_sum = sum + msm_pkg::MID_OFFSET;
   assign unit = offset_sum[msm_pkg::UNIT_BITS-1:0];
   assign recip_prod = 25'(unit) * 25'(257);

   always_ff @(posedge clock) begin
      unit_ff <= unit;
      quot_ff <= recip_prod[23:16];
      low_ff  <= offset_sum < 0;
      high_ff <= offset_sum > msm_pkg::LEVEL_SPAN;
   end

   assign quot_x255 = {quot_ff, 8'd0} - 16'(quot_ff);
   assign remainder = unit_ff - quot_x255;

   always_comb begin
      if (low_ff) begin
         level = '0;
      end else if (high_ff) begin
         level = '1;
      end else if (remainder >= 16'd255) begin
         level = quot_ff + 8'd1;
      end else begin
         level = quot_ff;
      end
   end

endmodule

@@ rtl/multichannel_sample_mixer.sv @@
// Channel  Direction  Transaction
// req_ch   in         one tick, play, stop or sample byte write
// rsp_ch   out        one mixed sample for each tick
//
// A play, stop or write transaction completes in the cycle it is accepted.
// A tick is accepted in an idle cycle and then keeps req_ch not ready until
// the mixer is back in ST_IDLE, so a new tick is not taken while one is still
// being mixed: each channel takes a sample memory read state (ST_READ) and a
// multiply state (ST_MULT) on the shared multiplier, then ST_SUM sums, ST_SCALE
// is the divide-by-255 stage and ST_OUT loads the output register.
// Reset is synchronous and clears the channel state; the sample memory is
// not cleared. A stalled result holds the mixer in its last tick cycle.
module multichannel_sample_mixer (
   input logic        clock,
   input logic        reset,
   msm_req_if.sink    req_ch,
   msm_rsp_if.source  rsp_ch
);

   msm_pkg::state_type state_ff, state_in;
   logic [msm_pkg::CH_IDX_BITS-1:0] idx_ff, idx_in;

   logic                           active_ff [msm_pkg::CHANNELS];
   logic                           loop_ff   [msm_pkg::CHANNELS];
   logic [msm_pkg::ADDR_BITS-1:0]  start_ff  [msm_pkg::CHANNELS];
   logic [msm_pkg::POS_BITS-1:0]   length_ff [msm_pkg::CHANNELS];
   logic [msm_pkg::VOL_BITS-1:0]   volume_ff [msm_pkg::CHANNELS];
   logic [msm_pkg::POS_BITS-1:0]   pos_ff    [msm_pkg::CHANNELS];

   logic [msm_pkg::SAMPLE_BITS-1:0] mem [msm_pkg::MEM_DEPTH];
   logic [msm_pkg::SAMPLE_BITS-1:0] rd_data_ff;
   logic [msm_pkg::ADDR_BITS-1:0]   rd_addr;

   logic signed [msm_pkg::PROD_BITS-1:0] prod_ff;
   logic signed [msm_pkg::SUM_BITS-1:0]  sum_ff;
   logic signed [8:0]                    centered;
   logic signed [17:0]                   full_prod;

   logic [msm_pkg::POS_BITS:0]      pos_inc;
   logic                            at_end;
   logic [msm_pkg::SAMPLE_BITS-1:0] level;
   logic                            rsp_valid_ff;
   logic [msm_pkg::SAMPLE_BITS-1:0] rsp_sample_ff;

   logic                            req_fire;
   logic                            chan_ok;
   logic [msm_pkg::CH_IDX_BITS-1:0] chan_sel;
   logic                            tick_start;
   logic                            req_ready;
   logic                            step_ch;
   logic                            acc_en;
   logic                            load_out;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign chan_ok = req_ch.channel < msm_pkg::CHAN_FIELD_BITS'(msm_pkg::CHANNELS);
   assign chan_sel = req_ch.channel[msm_pkg::CH_IDX_BITS-1:0];
   assign tick_start = req_fire && (req_ch.mode == msm_pkg::MODE_TICK);

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      unique case (state_ff)
         msm_pkg::ST_IDLE: begin
            idx_in = '0;
            if (tick_start) begin
               state_in = msm_pkg::ST_READ;
            end
         end
         msm_pkg::ST_READ: begin
            state_in = msm_pkg::ST_MULT;
         end
         msm_pkg::ST_MULT: begin
            if (idx_ff == msm_pkg::LAST_CH) begin
               state_in = msm_pkg::ST_SUM;
            end else begin
               idx_in = idx_ff + msm_pkg::CH_IDX_BITS'(1);
               state_in = msm_pkg::ST_READ;
            end
         end
         msm_pkg::ST_SUM: begin
            state_in = msm_pkg::ST_SCALE;
         end
         msm_pkg::ST_SCALE: begin
            state_in = msm_pkg::ST_OUT;
         end
         msm_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = msm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = msm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      step_ch = 1'b0;
      acc_en = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         msm_pkg::ST_IDLE:  req_ready = 1'b1;
         msm_pkg::ST_READ:  acc_en = 1'b1;
         msm_pkg::ST_MULT:  step_ch = 1'b1;
         msm_pkg::ST_SUM:   acc_en = 1'b1;
         msm_pkg::ST_SCALE: req_ready = 1'b0;
         msm_pkg::ST_OUT:   load_out = !rsp_valid_ff || rsp_ch.ready;
         default:           req_ready = 1'b0;
      endcase
   end

   assign req_ch.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msm_pkg::ST_IDLE;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
      end
   end

   assign rd_addr = start_ff[idx_ff] + pos_ff[idx_ff][msm_pkg::ADDR_BITS-1:0];

   always_ff @(posedge clock) begin
      if (req_fire && (req_ch.mode == msm_pkg::MODE_WRITE)) begin
         mem[req_ch.write_address] <= req_ch.write_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign pos_inc = {1'b0, pos_ff[idx_ff]} + (msm_pkg::POS_BITS + 1)'(1);
   assign at_end = pos_inc >= {1'b0, length_ff[idx_ff]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < msm_pkg::CHANNELS; i++) begin
            active_ff[i] <= 1'b0;
            loop_ff[i] <= 1'b0;
            start_ff[i] <= '0;
            length_ff[i] <= '0;
            volume_ff[i] <= '0;
            pos_ff[i] <= '0;
         end
      end else if (req_fire && chan_ok && (req_ch.mode == msm_pkg::MODE_PLAY)) begin
         active_ff[chan_sel] <= 1'b1;
         loop_ff[chan_sel] <= req_ch.loop_enable;
         start_ff[chan_sel] <= req_ch.clip_start;
         length_ff[chan_sel] <= req_ch.clip_length;
         volume_ff[chan_sel] <= req_ch.volume;
         pos_ff[chan_sel] <= '0;
      end else if (req_fire && chan_ok && (req_ch.mode == msm_pkg::MODE_STOP)) begin
         active_ff[chan_sel] <= 1'b0;
      end else if (step_ch && active_ff[idx_ff]) begin
         if (at_end && loop_ff[idx_ff]) begin
            pos_ff[idx_ff] <= '0;
         end else begin
            pos_ff[idx_ff] <= pos_inc[msm_pkg::POS_BITS-1:0];
         end
         if (at_end && !loop_ff[idx_ff]) begin
            active_ff[idx_ff] <= 1'b0;
         end
      end
   end

   // Flipping the top bit turns the unsigned byte into byte minus 128.
   assign centered = {~rd_data_ff[7], ~rd_data_ff[7], rd_data_ff[6:0]};
   assign full_prod = centered * $signed({1'b0, volume_ff[idx_ff]});

   always_ff @(posedge clock) begin
      if (tick_start) begin
         prod_ff <= '0;
         sum_ff <= '0;
      end else begin
         if (step_ch) begin
            prod_ff <= active_ff[idx_ff] ? full_prod[msm_pkg::PROD_BITS-1:0] : '0;
         end
         if (acc_en) begin
            sum_ff <= sum_ff + msm_pkg::SUM_BITS'(prod_ff);
         end
      end
   end

   msm_scale u_scale (
      .clock (clock),
      .sum   (sum_ff),
      .level (level)
   );

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_sample_ff <= level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.sample_out = rsp_sample_ff;

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == msm_pkg::ST_OUT))
      else $error("result appeared outside the output cycle");

   a_tick_starts_mix: assert property (@(posedge clock) disable iff (reset)
      tick_start |=> (state_ff == msm_pkg::ST_READ) && (idx_ff == '0))
      else $error("tick did not start the channel sweep at channel zero");

   a_last_channel_sums: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msm_pkg::ST_MULT) && (idx_ff == msm_pkg::LAST_CH)
      |=> state_ff == msm_pkg::ST_SUM)
      else $error("channel sweep did not end after the last channel");

   a_stalled_result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == msm_pkg::ST_OUT) && rsp_valid_ff && !rsp_ch.ready
      |=> state_ff == msm_pkg::ST_OUT)
      else $error("new result would overwrite a pending one");

endmodule
